FILE: rtl/spa_pkg.sv
// ----------------------------------------------------------------------------
// spa_pkg
// Shared constants, types and helper functions for the sliding phasor
// amplitude block.
// ----------------------------------------------------------------------------
package spa_pkg;

  localparam int WINDOW_LEN  = 20;
  localparam int GROUP_COUNT = 4;
  localparam int LANES       = GROUP_COUNT * 6;
  localparam int STORE_DEPTH = LANES * WINDOW_LEN;

  localparam int SLOT_W  = $clog2(WINDOW_LEN);
  localparam int LANE_W  = $clog2(LANES);
  localparam int ADDR_W  = $clog2(STORE_DEPTH);
  localparam int SCALE_W = 25;

  localparam logic [SCALE_W-1:0] SCALE_RESET = 25'd594936;
  localparam logic [30:0]        AMP_MAX     = 31'h7FFF_FFFF;

  // One input word as it travels from the front queue to the back end.
  typedef struct packed {
    logic [1:0]         group;
    logic signed [31:0] sample_a;
    logic signed [31:0] sample_b;
    logic signed [31:0] sample_c;
    logic signed [25:0] ref_cos;
    logic signed [25:0] ref_sin;
  } item_t;

  // Floor shift of a Q24 product by 24 with saturation to signed 32 bits.
  function automatic logic signed [31:0] sat_q24(input logic signed [57:0] p);
    logic signed [33:0] q;
    q = 34'(p >>> 24);
    if (q[33:31] == 3'b000 || q[33:31] == 3'b111) begin
      sat_q24 = q[31:0];
    end else if (q[33]) begin
      sat_q24 = 32'sh8000_0000;
    end else begin
      sat_q24 = 32'sh7FFF_FFFF;
    end
  endfunction

  // Magnitude of a signed 32-bit value as an unsigned 32-bit value.
  function automatic logic [31:0] abs32(input logic signed [31:0] v);
    abs32 = v[31] ? (~v + 32'd1) : v;
  endfunction

endpackage

FILE: rtl/spa_front.sv
// ----------------------------------------------------------------------------
// spa_front
// Accepts input words, drops words of a group beyond the group count and
// queues the rest in a two-entry buffer for the back end.
// ----------------------------------------------------------------------------
module spa_front (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  output logic               in_stall,
  input  spa_pkg::item_t     in_item,
  output logic               q_valid,
  input  logic               q_take,
  output spa_pkg::item_t     q_item
);
  import spa_pkg::*;

  item_t      buf_mem [2];
  logic       wr_ptr;
  logic       rd_ptr;
  logic [1:0] count;
  logic       accept;
  logic       keep;
  logic       pop;

  assign in_stall = (count == 2'd2);
  assign accept   = in_valid && !in_stall;
  assign keep     = accept && ({1'b0, in_item.group} < 3'(GROUP_COUNT));
  assign q_valid  = (count != 2'd0);
  assign q_item   = buf_mem[rd_ptr];
  assign pop      = q_take && q_valid;

  // Payload storage.
  always_ff @(posedge clk) begin
    if (keep) begin
      buf_mem[wr_ptr] <= in_item;
    end
  end

  // Pointers and fill count.
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      count  <= 2'd0;
    end else begin
      if (keep) begin
        wr_ptr <= ~wr_ptr;
      end
      if (pop) begin
        rd_ptr <= ~rd_ptr;
      end
      count <= count + {1'b0, keep} - {1'b0, pop};
    end
  end

endmodule

FILE: rtl/spa_root.sv
// ----------------------------------------------------------------------------
// spa_root
// Integer square root of a 64-bit value, two radicand bits per cycle.
// ----------------------------------------------------------------------------
module spa_root (
  input  logic        clk,
  input  logic        rst,
  input  logic        start,
  input  logic [63:0] radicand,
  output logic        done,
  output logic [31:0] root
);
  logic [63:0] rem;
  logic [63:0] res;
  logic [63:0] bitv;
  logic [4:0]  cnt;
  logic        busy;
  logic [63:0] trial;

  assign trial = res + bitv;
  assign root  = res[31:0];

  // One digit step per cycle while busy.
  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= 5'd0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        cnt  <= 5'd0;
      end else if (busy) begin
        cnt <= cnt + 5'd1;
        if (cnt == 5'd31) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  // Remainder and root datapath.
  always_ff @(posedge clk) begin
    if (start) begin
      rem  <= radicand;
      res  <= 64'd0;
      bitv <= 64'h4000_0000_0000_0000;
    end else if (busy) begin
      if (rem >= trial) begin
        rem <= rem - trial;
        res <= (res >> 1) + bitv;
      end else begin
        res <= res >> 1;
      end
      bitv <= bitv >> 2;
    end
  end

endmodule

FILE: rtl/spa_back.sv
// ----------------------------------------------------------------------------
// spa_back
// Carries out one queued word: two Q24 multiplies per lane, the sliding
// window update against the window store, and the amplitude of each signal.
// ----------------------------------------------------------------------------
module spa_back (
  input  logic                         clk,
  input  logic                         rst,
  input  logic [spa_pkg::SCALE_W-1:0]  scale,
  input  logic                         q_valid,
  output logic                         q_take,
  input  spa_pkg::item_t               q_item,
  output logic                         out_valid,
  input  logic                         out_stall,
  output logic [1:0]                   group_out,
  output logic [30:0]                  amplitude_a,
  output logic [30:0]                  amplitude_b,
  output logic [30:0]                  amplitude_c
);
  import spa_pkg::*;

  localparam logic [3:0] ST_CLEAR = 4'd0;
  localparam logic [3:0] ST_IDLE  = 4'd1;
  localparam logic [3:0] ST_MUL1  = 4'd2;
  localparam logic [3:0] ST_MUL2  = 4'd3;
  localparam logic [3:0] ST_ACC   = 4'd4;
  localparam logic [3:0] ST_SQC   = 4'd5;
  localparam logic [3:0] ST_SQS   = 4'd6;
  localparam logic [3:0] ST_RSTRT = 4'd7;
  localparam logic [3:0] ST_ROOT  = 4'd8;
  localparam logic [3:0] ST_DONE  = 4'd9;

  logic [3:0]         state;
  item_t              item;
  logic [2:0]         k;
  logic [SLOT_W-1:0]  slot;
  logic [ADDR_W-1:0]  clr_cnt;
  logic [31:0]        sums [LANES];
  logic [31:0]        store [STORE_DEPTH];
  logic [31:0]        rd_data;
  logic signed [57:0] p1;
  logic signed [57:0] p2;
  logic [31:0]        csum;
  logic [31:0]        ssum;
  logic [63:0]        sq;
  logic [30:0]        amp [3];

  logic [LANE_W-1:0]  lane;
  logic [ADDR_W-1:0]  addr;
  logic signed [31:0] x_sel;
  logic signed [25:0] r_sel;
  logic signed [31:0] v;
  logic [31:0]        new_sum;
  logic [31:0]        ca;
  logic [31:0]        sa;
  logic               root_start;
  logic               root_done;
  logic [31:0]        root;
  logic [32:0]        twice;
  logic [30:0]        amp_now;
  logic               out_free;

  // Lane and window store address of the current step.
  assign lane = LANE_W'({3'b000, item.group} * 5'd6 + {2'b00, k});
  assign addr = ADDR_W'(lane * ADDR_W'(WINDOW_LEN) + ADDR_W'(slot));

  // Operand selection: signal from the step's upper bits, cos or sin from bit 0.
  always_comb begin
    case (k[2:1])
      2'd0:    x_sel = item.sample_a;
      2'd1:    x_sel = item.sample_b;
      default: x_sel = item.sample_c;
    endcase
    r_sel = k[0] ? item.ref_sin : item.ref_cos;
  end

  assign v       = sat_q24(p2);
  assign new_sum = sums[lane] + v - rd_data;
  assign ca      = abs32(csum);
  assign sa      = abs32(ssum);
  assign twice   = {root, 1'b0};
  assign amp_now = (twice > {2'b00, AMP_MAX}) ? AMP_MAX : twice[30:0];
  assign out_free = !out_valid || !out_stall;
  assign q_take   = (state == ST_IDLE) && q_valid;
  assign root_start = (state == ST_RSTRT);

  spa_root u_root (
    .clk      (clk),
    .rst      (rst),
    .start    (root_start),
    .radicand (sq),
    .done     (root_done),
    .root     (root)
  );

  // Window store: clearing sweep after reset, one write per lane update.
  always_ff @(posedge clk) begin
    if (state == ST_CLEAR) begin
      store[clr_cnt] <= 32'd0;
    end else if (state == ST_ACC) begin
      store[addr] <= v;
    end
    rd_data <= store[addr];
  end

  // Multiplier pipeline and magnitude datapath.
  always_ff @(posedge clk) begin
    if (q_take) begin
      item <= q_item;
    end
    if (state == ST_MUL1) begin
      p1 <= x_sel * r_sel;
    end
    if (state == ST_MUL2) begin
      p2 <= $signed({1'b0, scale}) * sat_q24(p1);
    end
    if (state == ST_ACC) begin
      if (k[0]) begin
        ssum <= new_sum;
      end else begin
        csum <= new_sum;
      end
    end
    if (state == ST_SQC) begin
      sq <= ca * ca;
    end
    if (state == ST_SQS) begin
      sq <= sq + sa * sa;
    end
    if (state == ST_ROOT && root_done) begin
      amp[k[2:1]] <= amp_now;
    end
  end

  // Sequencer, running sums, slot pointer and output register.
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_CLEAR;
      clr_cnt   <= '0;
      k         <= 3'd0;
      slot      <= '0;
      out_valid <= 1'b0;
      for (int i = 0; i < LANES; i++) begin
        sums[i] <= 32'd0;
      end
    end else begin
      if (out_valid && !out_stall && state != ST_DONE) begin
        out_valid <= 1'b0;
      end
      case (state)
        ST_CLEAR: begin
          clr_cnt <= clr_cnt + 1'b1;
          if (clr_cnt == ADDR_W'(STORE_DEPTH - 1)) begin
            state <= ST_IDLE;
          end
        end
        ST_IDLE: begin
          if (q_valid) begin
            k     <= 3'd0;
            state <= ST_MUL1;
          end
        end
        ST_MUL1: state <= ST_MUL2;
        ST_MUL2: state <= ST_ACC;
        ST_ACC: begin
          sums[lane] <= new_sum;
          if (k[0]) begin
            state <= ST_SQC;
          end else begin
            k     <= k + 3'd1;
            state <= ST_MUL1;
          end
        end
        ST_SQC:   state <= ST_SQS;
        ST_SQS:   state <= ST_RSTRT;
        ST_RSTRT: state <= ST_ROOT;
        ST_ROOT: begin
          if (root_done) begin
            if (k == 3'd5) begin
              state <= ST_DONE;
            end else begin
              k     <= k + 3'd1;
              state <= ST_MUL1;
            end
          end
        end
        ST_DONE: begin
          if (out_free) begin
            out_valid   <= 1'b1;
            group_out   <= item.group;
            amplitude_a <= amp[0];
            amplitude_b <= amp[1];
            amplitude_c <= amp[2];
            if ({1'b0, item.group} == 3'(GROUP_COUNT - 1)) begin
              slot <= (slot == SLOT_W'(WINDOW_LEN - 1)) ? '0 : slot + 1'b1;
            end
            state <= ST_IDLE;
          end
        end
        default: state <= ST_IDLE;
      endcase
    end
  end

endmodule

FILE: rtl/sliding_phasor_amplitude_top.sv
// ----------------------------------------------------------------------------
// sliding_phasor_amplitude_top
// Sliding window amplitude of the fundamental for three signals per group.
//
//   Channel   Handshake            Payload
//   input     in_valid/in_stall    group, sample_a..c, ref_cos, ref_sin
//   output    out_valid/out_stall  group_out, amplitude_a..c
//   config    scale_we             scale_data (window_scale)
//
// In the back end a word is taken and then worked through its six lanes, two
// per signal, each with two multiplies and the window update; per signal
// then come the squares of the cos and sin sums, a root start and the square
// root, and last the result is registered in the output register.
// After reset a sweep clears the window store; words wait meanwhile.
// A two-entry queue takes words while the back end works, and the output
// register holds a word under stall while the next one is being computed.
// ----------------------------------------------------------------------------
module sliding_phasor_amplitude_top (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         scale_we,
  input  logic [spa_pkg::SCALE_W-1:0]  scale_data,
  input  logic                         in_valid,
  output logic                         in_stall,
  input  logic [1:0]                   group,
  input  logic signed [31:0]           sample_a,
  input  logic signed [31:0]           sample_b,
  input  logic signed [31:0]           sample_c,
  input  logic signed [25:0]           ref_cos,
  input  logic signed [25:0]           ref_sin,
  output logic                         out_valid,
  input  logic                         out_stall,
  output logic [1:0]                   group_out,
  output logic [30:0]                  amplitude_a,
  output logic [30:0]                  amplitude_b,
  output logic [30:0]                  amplitude_c
);
  import spa_pkg::*;

  logic [SCALE_W-1:0] window_scale;
  item_t              in_item;
  item_t              q_item;
  logic               q_valid;
  logic               q_take;

  // Scale register.
  always_ff @(posedge clk) begin
    if (rst) begin
      window_scale <= SCALE_RESET;
    end else if (scale_we) begin
      window_scale <= scale_data;
    end
  end

  assign in_item.group    = group;
  assign in_item.sample_a = sample_a;
  assign in_item.sample_b = sample_b;
  assign in_item.sample_c = sample_c;
  assign in_item.ref_cos  = ref_cos;
  assign in_item.ref_sin  = ref_sin;

  spa_front u_front (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .in_item  (in_item),
    .q_valid  (q_valid),
    .q_take   (q_take),
    .q_item   (q_item)
  );

  spa_back u_back (
    .clk         (clk),
    .rst         (rst),
    .scale       (window_scale),
    .q_valid     (q_valid),
    .q_take      (q_take),
    .q_item      (q_item),
    .out_valid   (out_valid),
    .out_stall   (out_stall),
    .group_out   (group_out),
    .amplitude_a (amplitude_a),
    .amplitude_b (amplitude_b),
    .amplitude_c (amplitude_c)
  );

endmodule
